>>> design/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_SPARE = 2'd3
  } policy_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_ALLOCATE = 1'b1;

  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned BIU_W    = 4;
  localparam logic [BIU_W-1:0] BIU_RESET = 4'd8;

endpackage

>>> design/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// An allocate is accepted only in the idle state; the scan then compares entries 0 to limit - 1,
// limit being blocks_in_use capped at NUM_BLOCKS (fewer under first fit), and the result waits
// in the done state until the output is free. A new request is stalled until then; the scan
// reads one table entry per cycle from the single read port. A load writes its entry on acceptance.
// Reset: asynchronous, active low; all free sizes read as zero through per-entry valid
// bits, policy returns to first fit and blocks_in_use to 8.

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [INDEX_W-1:0]    block_index_i,
  input  logic [SIZE_W-1:0]     amount_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [INDEX_W-1:0]    chosen_block_o
);

  localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = (CW > BIU_W) ? CW : BIU_W;
  localparam logic [LW-1:0] NB = LW'(NUM_BLOCKS);

  state_e state_q, state_d;

  logic [1:0]        policy_q;
  logic [BIU_W-1:0]  biu_q;
  logic [NUM_BLOCKS-1:0] valid_q;

  logic [SIZE_W-1:0] amt_q;
  logic [AW-1:0]     cmp_idx_q;
  logic              found_q, found_d;
  logic [AW-1:0]     pick_q, pick_d;
  logic [SIZE_W-1:0] pick_size_q, pick_size_d;

  logic              out_valid_q;
  logic              granted_q;
  logic [INDEX_W-1:0] chosen_q;

  logic [LW-1:0]     limit;
  logic [LW-1:0]     idx_ext;
  logic              in_acc;
  logic              load_hit;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SIZE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [SIZE_W-1:0] ram_rdata;
  logic [SIZE_W-1:0] eff_size;
  logic              fits, take, last, stop_first;
  logic              done_fire;

  assign limit    = (LW'(biu_q) > NB) ? NB : LW'(biu_q);
  assign idx_ext  = LW'(block_index_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign load_hit = in_acc && (mode_i == MODE_LOAD) && (idx_ext < NB);
  assign out_free = !out_valid_q || !out_stall_i;
  assign done_fire = (state_q == ST_DONE) && out_free;

  // Entries never written read as zero.
  assign eff_size = valid_q[cmp_idx_q] ? ram_rdata : '0;
  assign fits     = (eff_size >= amt_q);
  assign take     = fits && (!found_q ||
                    ((policy_q == POL_BEST)  && (eff_size < pick_size_q)) ||
                    ((policy_q == POL_WORST) && (eff_size > pick_size_q)));
  assign stop_first = fits && (policy_q != POL_BEST) && (policy_q != POL_WORST);
  assign last     = (LW'(cmp_idx_q) == (limit - LW'(1)));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_ext[AW-1:0];
    ram_wdata = amount_i;
    if (load_hit) begin
      ram_we = 1'b1;
    end else if (done_fire && found_q) begin
      ram_we    = 1'b1;
      ram_waddr = pick_q;
      ram_wdata = pick_size_q - amt_q;
    end
  end

  // Prefetch the next entry while comparing the current one.
  assign ram_raddr = (state_q == ST_SCAN) ? AW'(cmp_idx_q + AW'(1)) : '0;

  fpba_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(NUM_BLOCKS)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_ALLOCATE)) begin
          found_d = 1'b0;
          pick_d  = '0;
          state_d = (limit == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          found_d     = 1'b1;
          pick_d      = cmp_idx_q;
          pick_size_d = eff_size;
        end
        if (last || stop_first) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_FIRST;
      biu_q       <= BIU_RESET;
      valid_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLICY:        policy_q <= cfg_wdata_i[1:0];
          CFG_BLOCKS_IN_USE: biu_q    <= cfg_wdata_i[BIU_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    pick_size_q <= pick_size_d;
    if (in_acc) begin
      amt_q     <= amount_i;
      cmp_idx_q <= '0;
    end else if (state_q == ST_SCAN) begin
      cmp_idx_q <= AW'(cmp_idx_q + AW'(1));
    end
    if (done_fire) begin
      granted_q <= found_q;
      chosen_q  <= found_q ? INDEX_W'(pick_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;

endmodule

>>> design/fpba_ram.sv
`timescale 1ns / 1ps

module fpba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/fit_policy_block_allocator_test.sv
`timescale 1ns / 1ps

module fit_policy_block_allocator_test;
  import fpba_pkg::*;

  localparam int unsigned NUM_BLOCKS    = 8;
  localparam int unsigned SETTLE_CYCLES = 2 * NUM_BLOCKS + 4;
  localparam int unsigned TIMEOUT_NS    = 3_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] block;
  } grant_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  mode_i;
  logic [INDEX_W-1:0]    block_index_i;
  logic [SIZE_W-1:0]     amount_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  granted_o;
  logic [INDEX_W-1:0]    chosen_block_o;

  // Free-size table and registers as the block should hold them.
  logic [SIZE_W-1:0] free_model [NUM_BLOCKS];
  policy_e           model_policy;
  logic [BIU_W-1:0]  model_biu;

  grant_t pending_grants [$];
  int     fail_count;
  bit     send_idle_on;
  bit     recv_idle_on;
  int     hold_request;

  fit_policy_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .block_index_i (block_index_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .granted_o     (granted_o),
    .chosen_block_o(chosen_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("fit_policy_block_allocator regression: fail");
    $finish;
  end

  // Pick a block for the request by the current rule and take the space from it.
  function automatic grant_t take_block(input logic [SIZE_W-1:0] request);
    int unsigned span;
    int unsigned pick;
    bit          found;
    bit          done;
    grant_t      g;
    span  = (model_biu > NUM_BLOCKS) ? NUM_BLOCKS : model_biu;
    pick  = 0;
    found = 1'b0;
    done  = 1'b0;
    for (int unsigned k = 0; k < span && !done; k++) begin
      if (free_model[k] >= request) begin
        if (!found) begin
          found = 1'b1;
          pick  = k;
          // Spare code falls back to first fit.
          if (model_policy != POL_BEST && model_policy != POL_WORST) done = 1'b1;
        end else if (model_policy == POL_BEST && free_model[k] < free_model[pick]) begin
          pick = k;
        end else if (model_policy == POL_WORST && free_model[k] > free_model[pick]) begin
          pick = k;
        end
      end
    end
    g = '0;
    if (found) begin
      free_model[pick] = free_model[pick] - request;
      g.granted = 1'b1;
      g.block   = pick[INDEX_W-1:0];
    end
    return g;
  endfunction

  // Receiver: random stall bursts, calm stretches, and long hold-offs on request.
  initial begin : receiver
    int   stall_left;
    int   calm_left;
    int   hold_left;
    logic stall_next;
    out_stall_i = 1'b0;
    stall_left  = 0;
    calm_left   = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (!recv_idle_on) begin
        stall_left = 0;
        calm_left  = 0;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if (recv_idle_on) begin
        if ($urandom_range(0, 2) == 0) begin
          stall_left = $urandom_range(1, 17) - 1;
          stall_next = 1'b1;
        end else begin
          calm_left = $urandom_range(1, 40);
        end
      end
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing pending, expected none actual granted %0d block %0d",
                 $time, granted_o, chosen_block_o);
      end else begin
        want = pending_grants.pop_front();
        if (granted_o !== want.granted) begin
          fail_count++;
          $display("%0t: granted expected %0d actual %0d", $time, want.granted, granted_o);
        end
        if (chosen_block_o !== want.block) begin
          fail_count++;
          $display("%0t: chosen_block expected %0d actual %0d", $time, want.block,
                   chosen_block_o);
        end
      end
    end
  end

  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [SIZE_W-1:0] amt);
    int unsigned gap;
    gap = 0;
    if (send_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    block_index_i <= idx;
    amount_i      <= amt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mode == MODE_ALLOCATE) pending_grants.push_back(take_block(amt));
    else free_model[idx] = amt;
  endtask

  // Drop valid, wait out every pending result, then let any trailing load finish.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POLICY:        model_policy = policy_e'(data[1:0]);
      CFG_BLOCKS_IN_USE: model_biu = data[BIU_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input policy_e pol, input logic [BIU_W-1:0] biu);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    write_reg(CFG_POLICY, {junk, pol});
    write_reg(CFG_BLOCKS_IN_USE, biu);
  endtask

  task automatic send_random_item();
    logic              mode;
    logic [SIZE_W-1:0] amt;
    mode = ($urandom_range(0, 9) < 7) ? MODE_ALLOCATE : MODE_LOAD;
    case ($urandom_range(0, 9))
      0:       amt = '0;
      1:       amt = '1;
      2:       amt = free_model[$urandom_range(0, NUM_BLOCKS - 1)];
      3, 4:    amt = SIZE_W'($urandom_range(0, 65535));
      default: amt = (mode == MODE_LOAD) ? SIZE_W'($urandom_range(0, 4000))
                                         : SIZE_W'($urandom_range(0, 1500));
    endcase
    send_item(mode, INDEX_W'($urandom_range(0, NUM_BLOCKS - 1)), amt);
  endtask

  // Empty table after reset: a zero request fits block 0, anything else is refused.
  task automatic test_reset_state();
    send_item(MODE_ALLOCATE, 3'd5, 16'd0);
    send_item(MODE_ALLOCATE, 3'd2, 16'hFFFF);
    wait_idle();
  endtask

  task automatic test_policies();
    send_item(MODE_LOAD, 3'd0, 16'd100);
    send_item(MODE_LOAD, 3'd1, 16'd40);
    send_item(MODE_LOAD, 3'd2, 16'd300);
    send_item(MODE_LOAD, 3'd3, 16'd40);
    send_item(MODE_LOAD, 3'd4, 16'd0);
    send_item(MODE_LOAD, 3'd5, 16'd300);
    send_item(MODE_LOAD, 3'd6, 16'hFFFF);
    send_item(MODE_LOAD, 3'd7, 16'd7);
    wait_idle();
    set_config(POL_FIRST, 4'd8);
    send_item(MODE_ALLOCATE, 3'd7, 16'd50);
    wait_idle();
    // Two blocks tie on the smallest fit; the lower one must win.
    set_config(POL_BEST, 4'd8);
    send_item(MODE_ALLOCATE, 3'd0, 16'd40);
    wait_idle();
    set_config(POL_WORST, 4'd8);
    send_item(MODE_ALLOCATE, 3'd0, 16'd300);
    send_item(MODE_ALLOCATE, 3'd0, 16'hFFFF);
    wait_idle();
    set_config(POL_SPARE, 4'd8);
    send_item(MODE_ALLOCATE, 3'd0, 16'd7);
    wait_idle();
    set_config(POL_FIRST, 4'd0);
    send_item(MODE_ALLOCATE, 3'd0, 16'd0);
    wait_idle();
    set_config(POL_WORST, 4'd15);
    send_item(MODE_ALLOCATE, 3'd0, 16'd1);
    wait_idle();
    set_config(POL_BEST, 4'd1);
    send_item(MODE_ALLOCATE, 3'd0, 16'd44);
    wait_idle();
    // Writes to unlisted register indexes must leave the setup alone.
    write_reg(CFG_SPARE_LO, 4'hF);
    write_reg(CFG_SPARE_HI, 4'hF);
    send_item(MODE_ALLOCATE, 3'd0, 16'd43);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    policy_e          pol;
    logic [BIU_W-1:0] biu;
    for (int p = 0; p < phases; p++) begin
      pol = policy_e'(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        6:       biu = 4'd8;
        7:       biu = 4'd0;
        8:       biu = BIU_W'($urandom_range(9, 15));
        9:       biu = 4'd1;
        default: biu = BIU_W'($urandom_range(1, 8));
      endcase
      set_config(pol, biu);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'(CFG_SPARE_LO + $urandom_range(0, 1)),
                  CFG_DATA_W'($urandom_range(0, 15)));
      end
      send_idle_on = ($urandom_range(0, 4) != 0);
      repeat (per_phase) send_random_item();
      wait_idle();
    end
    send_idle_on = 1'b1;
  endtask

  // Hold the output long enough that the block backs up into its input.
  task automatic test_backpressure();
    set_config(POL_WORST, 4'd8);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      send_item(MODE_LOAD, INDEX_W'(k), SIZE_W'($urandom_range(2000, 65535)));
    end
    send_idle_on = 1'b0;
    hold_request = 150;
    repeat (20) begin
      send_item(MODE_ALLOCATE, INDEX_W'($urandom_range(0, 7)), SIZE_W'($urandom_range(0, 300)));
    end
    send_idle_on = 1'b1;
    wait_idle();
  endtask

  // Stop offering mid-phase until the block has drained, then carry on.
  task automatic test_sender_pause();
    set_config(POL_BEST, 4'd6);
    repeat (12) send_random_item();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (12) send_random_item();
    wait_idle();
  endtask

  task automatic test_streaming();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    set_config(POL_FIRST, 4'd8);
    repeat (40) send_random_item();
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_LOAD;
    block_index_i = '0;
    amount_i      = '0;
    fail_count    = 0;
    hold_request  = 0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    model_policy  = POL_FIRST;
    model_biu     = BIU_RESET;
    for (int k = 0; k < NUM_BLOCKS; k++) free_model[k] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_policies();
    test_random_traffic(10, 44);
    test_backpressure();
    test_sender_pause();
    test_streaming();

    if (fail_count == 0) begin
      $display("fit_policy_block_allocator regression: pass");
    end else begin
      $display("fit_policy_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
